### hdl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared types, constants and the arctangent table for the heading unit.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ATAN_IDX_W       = 5;

  localparam int XY_W   = 34;  // CORDIC x/y, signed, magnitude scaled by 2^16
  localparam int Z_W    = 30;  // angle accumulator, signed Q20 degrees
  localparam int ANG_W  = 29;  // folded angle, unsigned Q20 degrees
  localparam int HEAD_W = 15;
  localparam int SECT_W = 4;
  localparam int THR_W  = 15;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ANG_W-1:0]  DEG90_Q20  = ANG_W'(90 * (1 << 20));
  localparam logic [ANG_W-1:0]  DEG180_Q20 = ANG_W'(180 * (1 << 20));
  localparam logic [ANG_W-1:0]  DEG360_Q20 = ANG_W'(360 * (1 << 20));
  localparam logic [ANG_W-1:0]  ROUND_Q20  = ANG_W'(1 << 13);
  localparam logic [HEAD_W-1:0] FULL_Q6    = HEAD_W'(23040);
  localparam logic [HEAD_W-1:0] HALF_SECT  = HEAD_W'(720);
  // floor(v / 1440) == (v * 23302) >> 25 for every v below 2^16
  localparam logic [HEAD_W-1:0] SECT_RECIP = HEAD_W'(23302);
  localparam int                SECT_SHIFT = 25;

  localparam logic [THR_W-1:0]  CAL_THRESHOLD_RST = THR_W'(50);

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
  } mhs_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading_q6;
    logic [SECT_W-1:0] sector;
    logic              calibrated;
  } mhs_out_t;

  typedef struct packed {
    logic                  load_in;
    logic                  iter;
    logic [ATAN_IDX_W-1:0] step;
    logic                  fold;
    logic                  round;
    logic                  load_out;
  } mhs_cmd_t;

  function automatic logic [Z_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:  v = Z_W'(47185920);
      5'd1:  v = Z_W'(27855475);
      5'd2:  v = Z_W'(14718068);
      5'd3:  v = Z_W'(7471121);
      5'd4:  v = Z_W'(3750058);
      5'd5:  v = Z_W'(1876857);
      5'd6:  v = Z_W'(938658);
      5'd7:  v = Z_W'(469357);
      5'd8:  v = Z_W'(234682);
      5'd9:  v = Z_W'(117342);
      5'd10: v = Z_W'(58671);
      5'd11: v = Z_W'(29335);
      5'd12: v = Z_W'(14668);
      5'd13: v = Z_W'(7334);
      5'd14: v = Z_W'(3667);
      5'd15: v = Z_W'(1833);
      5'd16: v = Z_W'(917);
      5'd17: v = Z_W'(458);
      5'd18: v = Z_W'(229);
      5'd19: v = Z_W'(115);
      5'd20: v = Z_W'(57);
      5'd21: v = Z_W'(29);
      5'd22: v = Z_W'(14);
      5'd23: v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/magnetometer_heading_sector_unit.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_sector_unit
// Compass heading, 16-point sector and calibrated flag from an x/y sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one request holding a
//   signed x/y magnetometer sample. Output channel (out_valid/out_stall/
//   out_data) returns heading in 1/64 degree, sector 0..15 and the sticky
//   calibrated flag, one result per request.
//   The iterative CORDIC runs N = min(CORDIC_STEPS, 24) micro-rotations
//   (one micro-rotation per cycle), followed by the fold, round and sector
//   stages. One request in flight: a new request is accepted only after
//   the previous one has left the sector stage.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver still stalls when the next
//   result is ready, the unit holds that result internally and keeps
//   in_stall high until the output register frees.
//   Reset clears the calibrated flag, empties the output and sets
//   cal_threshold (APB byte address 0) to 50.
// ----------------------------------------------------------------------------
module magnetometer_heading_sector_unit #(
  parameter int CORDIC_STEPS = mhs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mhs_pkg::mhs_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mhs_pkg::mhs_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mhs_pkg::PADDR_W-1:0]  paddr,
  input  logic [mhs_pkg::PDATA_W-1:0]  pwdata,
  output logic [mhs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import mhs_pkg::*;

  localparam logic REG_CAL_THRESHOLD = 1'b0;

  logic [THR_W-1:0] cal_threshold;
  mhs_cmd_t         cmd;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_CAL_THRESHOLD) ? {{(PDATA_W-THR_W){1'b0}}, cal_threshold}
                                                  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_threshold <= CAL_THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_CAL_THRESHOLD)) begin
      cal_threshold <= pwdata[THR_W-1:0];
    end
  end

  mhs_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  mhs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_data      (in_data),
    .cal_threshold(cal_threshold),
    .out_data     (out_data)
  );

endmodule

### hdl/mhs_ctrl.sv
// ----------------------------------------------------------------------------
// mhs_ctrl
// Sequencer: request intake, CORDIC step count, finishing stages, output hold.
// ----------------------------------------------------------------------------
module mhs_ctrl #(
  parameter int CORDIC_STEPS = mhs_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output mhs_pkg::mhs_cmd_t cmd
);
  import mhs_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W = $clog2(NSTEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ITER  = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_SECT  = 3'd4;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              accept, load_out;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign load_out = (state == S_SECT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_ITER;
          step_next  = '0;
        end
      end
      S_ITER: begin
        if (step == LAST_STEP) begin
          state_next = S_FOLD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_FOLD:  state_next = S_ROUND;
      S_ROUND: state_next = S_SECT;
      S_SECT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd.load_in  = accept;
    cmd.iter     = (state == S_ITER);
    cmd.step     = ATAN_IDX_W'(step);
    cmd.fold     = (state == S_FOLD);
    cmd.round    = (state == S_ROUND);
    cmd.load_out = load_out;
  end

endmodule

### hdl/mhs_datapath.sv
// ----------------------------------------------------------------------------
// mhs_datapath
// Vectoring CORDIC, quadrant fold, rounding, sector and calibration flag.
// ----------------------------------------------------------------------------
module mhs_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  mhs_pkg::mhs_cmd_t          cmd,
  input  mhs_pkg::mhs_in_t           in_data,
  input  logic [mhs_pkg::THR_W-1:0]  cal_threshold,
  output mhs_pkg::mhs_out_t          out_data
);
  import mhs_pkg::*;

  logic signed [XY_W-1:0] x, y;
  logic signed [Z_W-1:0]  z;
  logic                   neg_x, neg_y, is_zero;
  logic                   cal_flag;
  logic [ANG_W-1:0]       ang;
  logic [HEAD_W-1:0]      heading;

  logic [16:0]            ax, ay;
  logic signed [XY_W-1:0] xs, ys;
  logic [Z_W-1:0]         dz;
  logic [ANG_W-1:0]       t, ang_next;
  logic [ANG_W-1:0]       rsum;
  logic [HEAD_W-1:0]      hraw;
  logic [HEAD_W-1:0]      vsec;
  logic [2*HEAD_W-1:0]    prod;

  assign ax = in_data.mag_x[15] ? (17'd0 - {in_data.mag_x[15], in_data.mag_x})
                                : {1'b0, in_data.mag_x};
  assign ay = in_data.mag_y[15] ? (17'd0 - {in_data.mag_y[15], in_data.mag_y})
                                : {1'b0, in_data.mag_y};

  assign xs = x >>> cmd.step;
  assign ys = y >>> cmd.step;
  assign dz = atan_q20(cmd.step);

  always_comb begin
    if (z[Z_W-1]) begin
      t = '0;
    end else if (ANG_W'(z) > DEG90_Q20) begin
      t = DEG90_Q20;
    end else begin
      t = ANG_W'(z);
    end
    case ({neg_x, neg_y})
      2'b00:   ang_next = t;
      2'b10:   ang_next = DEG180_Q20 - t;
      2'b11:   ang_next = DEG180_Q20 + t;
      default: ang_next = DEG360_Q20 - t;
    endcase
  end

  assign rsum = ang + ROUND_Q20;
  assign hraw = rsum[ANG_W-1:14];
  assign vsec = heading + HALF_SECT;
  assign prod = vsec * SECT_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_flag <= 1'b0;
    end else if (cmd.load_in && ((ax > {2'b00, cal_threshold}) ||
                                 (ay > {2'b00, cal_threshold}))) begin
      cal_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x       <= {1'b0, ax, 16'd0};
      y       <= {1'b0, ay, 16'd0};
      z       <= '0;
      neg_x   <= in_data.mag_x[15];
      neg_y   <= in_data.mag_y[15];
      is_zero <= (ax == '0) && (ay == '0);
    end else if (cmd.iter) begin
      if (!y[XY_W-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + $signed(dz);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - $signed(dz);
      end
    end
    if (cmd.fold) begin
      ang <= ang_next;
    end
    if (cmd.round) begin
      if (is_zero) begin
        heading <= '0;
      end else if (hraw >= FULL_Q6) begin
        heading <= hraw - FULL_Q6;
      end else begin
        heading <= hraw;
      end
    end
    if (cmd.load_out) begin
      out_data.heading_q6 <= heading;
      out_data.sector     <= prod[SECT_SHIFT+SECT_W-1:SECT_SHIFT];
      out_data.calibrated <= cal_flag;
    end
  end

endmodule
